/* rtl/wrsi_pkg.sv */
// Shared types and constants for the Wilder RSI stream block.
// Used by the divider, datapath, controller and top level. No dependencies.
`timescale 1ns / 1ps
package wrsi_pkg;

   localparam int PRICE_W     = 32;
   localparam int PERIOD_W    = 8;
   localparam int COUNT_W     = 9;
   localparam int AVG_W       = 56;
   localparam int RSI_W       = 23;
   localparam int EXTRA_FRAC  = 16;
   localparam int DIVIDEND_W  = 64;
   localparam int DIVISOR_W   = AVG_W + 1;
   localparam int REM_W       = DIVISOR_W + 1;
   localparam int STEPS_W     = 7;
   localparam int PROD_W      = AVG_W + RSI_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;
   localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;
   localparam logic [STEPS_W-1:0]  AVG_STEPS    = 7'd64;
   localparam logic [STEPS_W-1:0]  RATIO_STEPS  = 7'd23;

   typedef struct packed {
      logic [PRICE_W-1:0] price_sample;
      logic               first_of_series;
   } req_payload_type;

   typedef struct packed {
      logic [RSI_W-1:0] rsi_value;
      logic             rsi_valid;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      DIV_SEL_GAIN,
      DIV_SEL_LOSS,
      DIV_SEL_RATIO
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDEND,
      ST_GAIN_START,
      ST_GAIN_RUN,
      ST_LOSS_START,
      ST_LOSS_RUN,
      ST_LOSS_STORE,
      ST_RATIO_CHECK,
      ST_DECIDE,
      ST_RATIO_MUL,
      ST_RATIO_SUM,
      ST_RATIO_START,
      ST_RATIO_RUN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        update;
      logic        dividend;
      logic        div_start;
      div_sel_type div_sel;
      logic        store_gain;
      logic        store_loss;
      logic        ratio_mul;
      logic        ratio_sum;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic need_ratio;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/wilder_rsi_stream.sv */
// Top level of the Wilder RSI stream block: controller, datapath, ports.
// Depends on wrsi_pkg, wrsi_ctrl and wrsi_datapath.
//
// Usage: an item on req_payload (price sample, first-of-series flag) is taken
// when req_valid is high and req_stall is low. Each item gives one result on
// rsp_payload (RSI value in Q7.16, valid flag), held while rsp_stall is high.
// The block works on one item at a time; req_stall is high while it does.
// A first or warm-up sample goes from the update straight to the result. Other
// samples divide both averages by the period, and a valid result with nonzero
// loss needs the ratio as well. The bit-serial divider, shared by the two
// average divisions (64 steps each) and the ratio (23 steps), does this work.
// The next item can be taken in the cycle after the result is loaded.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result is held back until the previous one is taken.
// The period register is written from csr_data when csr_valid and csr_ready
// are high; csr_ready is high only while the block is idle and no item is
// offered.
// Synchronous reset empties the output, clears the series state and sets the
// period to 14.
`timescale 1ns / 1ps
module wilder_rsi_stream (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wrsi_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wrsi_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wrsi_pkg::PERIOD_W-1:0] csr_data
);
   import wrsi_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = !req_stall && !req_valid;

   wrsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wrsi_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );
endmodule

/* rtl/wrsi_div.sv */
// Bit-serial restoring divider shared by the average and ratio divisions.
// Depends on wrsi_pkg for widths.
`timescale 1ns / 1ps
module wrsi_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wrsi_pkg::REM_W-1:0]       rem_init,
   input  logic [wrsi_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [wrsi_pkg::DIVISOR_W-1:0]   divisor,
   input  logic [wrsi_pkg::STEPS_W-1:0]     steps,
   output logic                             done,
   output logic [wrsi_pkg::DIVIDEND_W-1:0]  quotient
);
   import wrsi_pkg::*;

   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [STEPS_W-1:0]    left_ff, left_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [REM_W-1:0]      trial;
   logic [REM_W-1:0]      dvs_ext;

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      left_in  = left_ff;
      run_in   = run_ff;
      done_in  = done_ff;
      trial    = {rem_ff[REM_W-2:0], shift_ff[DIVIDEND_W-1]};
      dvs_ext  = {1'b0, dvs_ff};
      if (start) begin
         rem_in   = rem_init;
         shift_in = dividend;
         quo_in   = '0;
         dvs_in   = divisor;
         left_in  = steps;
         run_in   = 1'b1;
         done_in  = 1'b0;
      end else if (run_ff) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= dvs_ext) begin
            rem_in = trial - dvs_ext;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         left_in = left_ff - 1'b1;
         if (left_ff == STEPS_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      left_ff  <= left_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/wrsi_datapath.sv */
// Datapath: series state, smoothing multiply, ratio product, divider and
// output register. Depends on wrsi_pkg and wrsi_div.
`timescale 1ns / 1ps
module wrsi_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  wrsi_pkg::ctrl_cmd_type        cmd,
   output wrsi_pkg::dp_status_type       status,
   input  wrsi_pkg::req_payload_type     req_payload,
   input  logic                          csr_write,
   input  logic [wrsi_pkg::PERIOD_W-1:0] csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wrsi_pkg::rsp_payload_type     rsp_payload
);
   import wrsi_pkg::*;

   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PRICE_W-1:0]    price_ff, price_in;
   logic                  first_ff, first_in;
   logic [PRICE_W-1:0]    prev_ff, prev_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [AVG_W-1:0]      gain_ff, gain_in;
   logic [AVG_W-1:0]      loss_ff, loss_in;
   logic [PRICE_W-1:0]    up_ff, up_in;
   logic [PRICE_W-1:0]    down_ff, down_in;
   logic                  smooth_ff, smooth_in;
   logic                  need_div_ff, need_div_in;
   logic [DIVIDEND_W-1:0] dg_ff, dg_in;
   logic [DIVIDEND_W-1:0] dl_ff, dl_in;
   logic [54:0]           plo_ff, plo_in;
   logic [46:0]           phi_ff, phi_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIVISOR_W-1:0]  sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [PERIOD_W-1:0]   period_eff;
   logic [PERIOD_W-1:0]   keep;
   logic [COUNT_W-1:0]    cnt;
   logic [COUNT_W-1:0]    period_ext;
   logic [DIVIDEND_W-1:0] mg, ml;
   logic                  valid_now;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] quotient;
   logic [REM_W-1:0]      div_rem;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [STEPS_W-1:0]    div_steps;

   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign keep       = period_eff - 1'b1;
   assign period_ext = {1'b0, period_eff};
   assign valid_now  = count_ff > period_ext;

   always_comb begin
      period_in    = csr_write ? csr_data : period_ff;
      price_in     = price_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      smooth_in    = smooth_ff;
      need_div_in  = need_div_ff;
      dg_in        = dg_ff;
      dl_in        = dl_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt          = first_ff ? '0 : count_ff;
      mg           = DIVIDEND_W'(gain_ff) * DIVIDEND_W'(keep);
      ml           = DIVIDEND_W'(loss_ff) * DIVIDEND_W'(keep);

      if (cmd.load) begin
         price_in = req_payload.price_sample;
         first_in = req_payload.first_of_series;
      end

      if (cmd.update) begin
         prev_in = price_ff;
         if (cnt == '0) begin
            gain_in     = '0;
            loss_in     = '0;
            count_in    = COUNT_W'(1);
            smooth_in   = 1'b0;
            need_div_in = 1'b0;
         end else begin
            if (price_ff > prev_ff) begin
               up_in   = price_ff - prev_ff;
               down_in = '0;
            end else begin
               up_in   = '0;
               down_in = prev_ff - price_ff;
            end
            if (cnt <= period_ext) begin
               gain_in     = gain_ff + AVG_W'(up_in);
               loss_in     = loss_ff + AVG_W'(down_in);
               smooth_in   = 1'b0;
               need_div_in = (cnt == period_ext);
            end else begin
               smooth_in   = 1'b1;
               need_div_in = 1'b1;
            end
            count_in = (cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;
         end
      end

      // Dividends wrap at 64 bits, matching the unsigned arithmetic of the series.
      if (cmd.dividend) begin
         if (smooth_ff) begin
            dg_in = mg + (DIVIDEND_W'(up_ff) << EXTRA_FRAC);
            dl_in = ml + (DIVIDEND_W'(down_ff) << EXTRA_FRAC);
         end else begin
            dg_in = DIVIDEND_W'(gain_ff) << EXTRA_FRAC;
            dl_in = DIVIDEND_W'(loss_ff) << EXTRA_FRAC;
         end
      end

      if (cmd.store_gain) gain_in = quotient[AVG_W-1:0];
      if (cmd.store_loss) loss_in = quotient[AVG_W-1:0];

      // The full-scale product is split into two partial products.
      if (cmd.ratio_mul) begin
         plo_in = 55'(gain_ff[31:0]) * 55'(RSI_FULL);
         phi_in = 47'(gain_ff[AVG_W-1:32]) * 47'(RSI_FULL);
         sum_in = {1'b0, gain_ff} + {1'b0, loss_ff};
      end
      if (cmd.ratio_sum) begin
         prod_in = PROD_W'(plo_ff) + (PROD_W'(phi_ff) << 32);
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.rsi_valid = valid_now;
         if (!valid_now) begin
            rsp_in.rsi_value = '0;
         end else if (loss_ff == '0) begin
            rsp_in.rsi_value = RSI_FULL;
         end else begin
            rsp_in.rsi_value = quotient[RSI_W-1:0];
         end
      end
   end

   always_comb begin
      div_rem      = '0;
      div_dividend = dg_ff;
      div_divisor  = DIVISOR_W'(period_eff);
      div_steps    = AVG_STEPS;
      case (cmd.div_sel)
         DIV_SEL_GAIN: begin
            div_dividend = dg_ff;
         end
         DIV_SEL_LOSS: begin
            div_dividend = dl_ff;
         end
         DIV_SEL_RATIO: begin
            // The quotient fits 23 bits, so the upper product bits start as remainder.
            div_rem      = REM_W'(prod_ff[PROD_W-1:RSI_W]);
            div_dividend = {prod_ff[RSI_W-1:0], {(DIVIDEND_W-RSI_W){1'b0}}};
            div_divisor  = sum_ff;
            div_steps    = RATIO_STEPS;
         end
         default: begin
            div_dividend = dg_ff;
         end
      endcase
   end

   wrsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .rem_init (div_rem),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         prev_ff      <= '0;
         count_ff     <= '0;
         gain_ff      <= '0;
         loss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         gain_ff      <= gain_in;
         loss_ff      <= loss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff    <= price_in;
      first_ff    <= first_in;
      up_ff       <= up_in;
      down_ff     <= down_in;
      smooth_ff   <= smooth_in;
      need_div_ff <= need_div_in;
      dg_ff       <= dg_in;
      dl_ff       <= dl_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rsp_ff      <= rsp_in;
   end

   assign status.need_div   = need_div_ff;
   assign status.need_ratio = valid_now && (loss_ff != '0);
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;
endmodule

/* rtl/wrsi_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
// Depends on wrsi_pkg for the state, command and status types.
`timescale 1ns / 1ps
module wrsi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wrsi_pkg::dp_status_type status,
   output wrsi_pkg::ctrl_cmd_type  cmd
);
   import wrsi_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE:      state_in = ST_DECIDE;
         ST_DIVIDEND:    state_in = ST_GAIN_START;
         ST_GAIN_START:  state_in = ST_GAIN_RUN;
         ST_GAIN_RUN:    if (status.div_done) state_in = ST_LOSS_START;
         ST_LOSS_START:  state_in = ST_LOSS_RUN;
         ST_LOSS_RUN:    if (status.div_done) state_in = ST_LOSS_STORE;
         ST_LOSS_STORE:  state_in = ST_RATIO_CHECK;
         ST_RATIO_CHECK: begin
            // Averages are final here; a valid result with nonzero loss needs the ratio.
            if (status.need_ratio) begin
               state_in = ST_RATIO_MUL;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DECIDE: begin
            if (status.need_div) begin
               state_in = ST_DIVIDEND;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_RATIO_MUL:   state_in = ST_RATIO_SUM;
         ST_RATIO_SUM:   state_in = ST_RATIO_START;
         ST_RATIO_START: state_in = ST_RATIO_RUN;
         ST_RATIO_RUN:   if (status.div_done) state_in = ST_RESULT;
         ST_RESULT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_SEL_GAIN;
      case (state_ff)
         ST_IDLE:        cmd.load = req_valid;
         ST_UPDATE:      cmd.update = 1'b1;
         ST_DIVIDEND:    cmd.dividend = 1'b1;
         ST_GAIN_START:  cmd.div_start = 1'b1;
         ST_LOSS_START: begin
            cmd.store_gain = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_sel    = DIV_SEL_LOSS;
         end
         ST_LOSS_STORE: begin
            cmd.store_loss = 1'b1;
            cmd.div_start  = 1'b0;
         end
         ST_RATIO_MUL:   cmd.ratio_mul = 1'b1;
         ST_RATIO_SUM:   cmd.ratio_sum = 1'b1;
         ST_RATIO_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_RATIO;
         end
         ST_RESULT: begin
            cmd.out_load = status.out_free;
         end
         default:        cmd.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
endmodule
